// File: rtl/smlc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smlc_pkg: shared types and constants for the substring matcher
// Result kinds, register indexes and the flags carried by each queue entry.
// ----------------------------------------------------------------------------
package smlc_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 64;
  localparam int LEN_REG_W   = 4;

  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN        = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 1'b1;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  // entries in the front-to-back queue
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_MATCH     = 2'd0,
    KIND_EOF_NONE  = 2'd1,
    KIND_EOF_FOUND = 2'd2
  } kind_t;

  typedef struct packed {
    logic hit;   // entry carries a match start position
    logic eof;   // entry closes a file
    logic seen;  // any match in this file, up to and including this byte
  } entry_flags_t;

  localparam int FLAGS_W = $bits(entry_flags_t);

endpackage

// File: rtl/smlc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smlc_if: stream channels of the substring matcher
// Text byte input channel and match/status result channel.
// ----------------------------------------------------------------------------
interface smlc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_file;

  modport source (output valid, output text_byte, output end_of_file, input ready);
  modport sink   (input valid, input text_byte, input end_of_file, output ready);
endinterface

interface smlc_out_if #(
  parameter int LINE_WIDTH   = 20,
  parameter int COLUMN_WIDTH = 16
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              kind;
  logic [LINE_WIDTH-1:0]   line_number;
  logic [COLUMN_WIDTH-1:0] column_number;
  logic                    last;

  modport source (output valid, output kind, output line_number, output column_number,
                  output last, input ready);
  modport sink   (input valid, input kind, input line_number, input column_number,
                  input last, output ready);
endinterface

// File: rtl/smlc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smlc_queue: small register queue between front and back
// Holds classified entries so that the two sides stall independently.
// ----------------------------------------------------------------------------
module smlc_queue #(
  parameter int DATA_W = 39
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic              full,
  output logic              head_valid,
  output logic [DATA_W-1:0] head_data
);
  import smlc_pkg::*;

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0]  slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;

  assign full       = (count == COUNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + COUNT_W'(1);
      end else if (pop && !push) begin
        count <= count - COUNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/smlc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smlc_front: byte intake, window and pattern compare
// Shifts each byte into the tagged window, compares it with the pattern and
// pushes an entry for every match or end of file.
// ----------------------------------------------------------------------------
module smlc_front #(
  parameter int PATTERN_MAX  = 8,
  parameter int LINE_WIDTH   = 20,
  parameter int COLUMN_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [smlc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [smlc_pkg::CFG_DATA_W-1:0]     cfg_data,
  smlc_in_if.sink                             in_ch,
  input  logic                                queue_full,
  output logic                                push,
  output smlc_pkg::entry_flags_t              push_flags,
  output logic [LINE_WIDTH-1:0]               push_line,
  output logic [COLUMN_WIDTH-1:0]             push_column
);
  import smlc_pkg::*;

  localparam int FILL_W = $clog2(PATTERN_MAX + 1);
  localparam int LANE_W = $clog2(PATTERN_MAX);

  logic [CFG_DATA_W-1:0] pattern;
  logic [LEN_REG_W-1:0]  pattern_length;

  logic [7:0]              win_bytes   [PATTERN_MAX];
  logic [LINE_WIDTH-1:0]   win_lines   [PATTERN_MAX];
  logic [COLUMN_WIDTH-1:0] win_columns [PATTERN_MAX];
  logic [FILL_W-1:0]       fill;
  logic [LINE_WIDTH-1:0]   current_line;
  logic [COLUMN_WIDTH-1:0] current_column;
  logic                    match_seen;

  logic [7:0]              bytes_next   [PATTERN_MAX];
  logic [LINE_WIDTH-1:0]   lines_next   [PATTERN_MAX];
  logic [COLUMN_WIDTH-1:0] columns_next [PATTERN_MAX];
  logic [FILL_W-1:0]       fill_next;
  logic [LINE_WIDTH-1:0]   line_next;
  logic [COLUMN_WIDTH-1:0] column_next;

  logic [FILL_W-1:0]      len;
  logic [FILL_W-1:0]      len_m1;
  logic [7:0]             want [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] lane_ok;
  logic                   hit;
  logic                   accept;

  assign in_ch.ready = !queue_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // effective pattern length, clamped to 1..PATTERN_MAX
  always_comb begin
    if (pattern_length == '0) begin
      len = FILL_W'(1);
    end else if (int'(pattern_length) > PATTERN_MAX) begin
      len = FILL_W'(PATTERN_MAX);
    end else begin
      len = pattern_length[FILL_W-1:0];
    end
  end
  assign len_m1 = len - FILL_W'(1);

  // window after this byte is shifted in
  always_comb begin
    bytes_next[0]   = in_ch.text_byte;
    lines_next[0]   = current_line;
    columns_next[0] = current_column;
    for (int i = 1; i < PATTERN_MAX; i++) begin
      bytes_next[i]   = win_bytes[i-1];
      lines_next[i]   = win_lines[i-1];
      columns_next[i] = win_columns[i-1];
    end
    fill_next = (int'(fill) < PATTERN_MAX) ? fill + FILL_W'(1) : fill;
  end

  // pattern byte expected at each lane, newest lane holds the last character
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      want[i] = '0;
      for (int l = 1; l <= PATTERN_MAX; l++) begin
        if (int'(len) == l && i < l) begin
          want[i] = pattern[8*(l-1-i) +: 8];
        end
      end
      lane_ok[i] = (i >= int'(len)) || (bytes_next[i] == want[i]);
    end
  end

  assign hit = (fill_next >= len) && (&lane_ok);

  // saturating position counters
  always_comb begin
    line_next   = current_line;
    column_next = current_column;
    if (in_ch.text_byte == NEWLINE_BYTE) begin
      if (current_line != '1) begin
        line_next = current_line + LINE_WIDTH'(1);
      end
      column_next = '0;
    end else if (current_column != '1) begin
      column_next = current_column + COLUMN_WIDTH'(1);
    end
  end

  assign push            = accept && (hit || in_ch.end_of_file);
  assign push_flags.hit  = hit;
  assign push_flags.eof  = in_ch.end_of_file;
  assign push_flags.seen = match_seen || hit;
  assign push_line       = lines_next[len_m1[LANE_W-1:0]];
  assign push_column     = columns_next[len_m1[LANE_W-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern        <= '0;
      pattern_length <= LEN_REG_W'(1);
    end else if (cfg_write) begin
      if (cfg_index == CFG_PATTERN) begin
        pattern <= cfg_data;
      end else if (cfg_index == CFG_PATTERN_LENGTH) begin
        pattern_length <= cfg_data[LEN_REG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && in_ch.end_of_file)) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        win_bytes[i]   <= '0;
        win_lines[i]   <= '0;
        win_columns[i] <= '0;
      end
      fill           <= '0;
      current_line   <= LINE_WIDTH'(1);
      current_column <= '0;
      match_seen     <= 1'b0;
    end else if (accept) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        win_bytes[i]   <= bytes_next[i];
        win_lines[i]   <= lines_next[i];
        win_columns[i] <= columns_next[i];
      end
      fill           <= fill_next;
      current_line   <= line_next;
      current_column <= column_next;
      match_seen     <= match_seen || hit;
    end
  end

endmodule

// File: rtl/smlc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smlc_back: result sequencer
// Turns each queue entry into a match result, a status result, or both,
// through a registered output stage.
// ----------------------------------------------------------------------------
module smlc_back #(
  parameter int LINE_WIDTH   = 20,
  parameter int COLUMN_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    head_valid,
  input  smlc_pkg::entry_flags_t  head_flags,
  input  logic [LINE_WIDTH-1:0]   head_line,
  input  logic [COLUMN_WIDTH-1:0] head_column,
  output logic                    pop,
  smlc_out_if.source              out_ch
);
  import smlc_pkg::*;

  logic load;
  logic hit_done;    // match of the head entry already sent, status still due
  logic emit_match;

  assign load       = head_valid && (!out_ch.valid || out_ch.ready);
  assign emit_match = head_flags.hit && !hit_done;
  assign pop        = load && !(emit_match && head_flags.eof);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
      hit_done     <= 1'b0;
    end else begin
      if (load) begin
        out_ch.valid <= 1'b1;
        hit_done     <= emit_match && head_flags.eof;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (emit_match) begin
        out_ch.kind          <= KIND_MATCH;
        out_ch.line_number   <= head_line;
        out_ch.column_number <= head_column;
        out_ch.last          <= !head_flags.eof;
      end else begin
        out_ch.kind          <= head_flags.seen ? KIND_EOF_FOUND : KIND_EOF_NONE;
        out_ch.line_number   <= '0;
        out_ch.column_number <= '0;
        out_ch.last          <= 1'b1;
      end
    end
  end

  // pending status always belongs to an entry still at the head
  a_hit_done_head: assert property (@(posedge clk) disable iff (rst)
    hit_done |-> head_valid && head_flags.eof && head_flags.hit)
    else $error("pending status without end-of-file head entry");

  // status results close the item and carry no position
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.kind != KIND_MATCH) |->
      out_ch.last && (out_ch.line_number == '0) && (out_ch.column_number == '0))
    else $error("status result malformed");

  // a split entry is popped on the cycle its status is loaded
  a_split_pop: assert property (@(posedge clk) disable iff (rst)
    hit_done && load |-> pop)
    else $error("split entry not retired after status");

endmodule

// File: rtl/substring_match_line_column_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_match_line_column_top: streaming substring search with positions
// Finds every occurrence of a 1..8 byte pattern in a byte stream, reporting
// the start line and column of each, and a status at every end of file.
// ----------------------------------------------------------------------------
// path: a byte transfer writes the queue, and the output register is then loaded from
//   the queue head when the output is free
// throughput: one byte per cycle while the queue is not full; a final byte that
//   also completes a match gives two results, match then status, through the output register
// reset: synchronous, active high; clears window, counters, queue and output,
//   pattern to 0 and pattern length to 1; no clearing pass
module substring_match_line_column_top #(
  parameter int PATTERN_MAX  = 8,
  parameter int LINE_WIDTH   = 20,
  parameter int COLUMN_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [smlc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [smlc_pkg::CFG_DATA_W-1:0]  cfg_data,
  smlc_in_if.sink                          in_ch,
  smlc_out_if.source                       out_ch
);
  import smlc_pkg::*;

  // queue entry layout: flags, then start line, then start column
  localparam int ENTRY_W = FLAGS_W + LINE_WIDTH + COLUMN_WIDTH;

  logic                    push;
  entry_flags_t            push_flags;
  logic [LINE_WIDTH-1:0]   push_line;
  logic [COLUMN_WIDTH-1:0] push_column;
  logic                    queue_full;

  logic                    pop;
  logic                    head_valid;
  logic [ENTRY_W-1:0]      head_data;
  entry_flags_t            head_flags;
  logic [LINE_WIDTH-1:0]   head_line;
  logic [COLUMN_WIDTH-1:0] head_column;

  // front: window shift, parallel compare of all lanes, position counters
  smlc_front #(
    .PATTERN_MAX  (PATTERN_MAX),
    .LINE_WIDTH   (LINE_WIDTH),
    .COLUMN_WIDTH (COLUMN_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_ch       (in_ch),
    .queue_full  (queue_full),
    .push        (push),
    .push_flags  (push_flags),
    .push_line   (push_line),
    .push_column (push_column)
  );

  // only bytes that cause a result take a queue slot
  smlc_queue #(
    .DATA_W (ENTRY_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({push_flags, push_line, push_column}),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  assign head_flags  = entry_flags_t'(head_data[ENTRY_W-1 -: FLAGS_W]);
  assign head_line   = head_data[COLUMN_WIDTH +: LINE_WIDTH];
  assign head_column = head_data[COLUMN_WIDTH-1:0];

  // back: one or two result transfers per entry, match before status
  smlc_back #(
    .LINE_WIDTH   (LINE_WIDTH),
    .COLUMN_WIDTH (COLUMN_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_flags  (head_flags),
    .head_line   (head_line),
    .head_column (head_column),
    .pop         (pop),
    .out_ch      (out_ch)
  );

endmodule
